// ===== rtl/nvcp_pkg.sv =====
// nvcp_pkg: shared types and constants of the name=value command parser
// no dependencies; imported by the channel interfaces and all rtl modules
package nvcp_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SLOT_W   = 64;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned MANT_W   = 32;
  localparam int unsigned PLACES_W = 8;
  localparam int unsigned REG_W    = 3;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // special characters
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_EQ    = 8'h3D;
  localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;

  // mantissa limits
  localparam logic signed [MANT_W-1:0] MANT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [MANT_W-1:0] MANT_MIN = 32'sh8000_0000;

  // places limit
  localparam logic [PLACES_W-1:0] PLACES_MAX = 8'hFF;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_NAME_COUNT = 3'd0;
  localparam logic [REG_W-1:0] REG_NAME_SLOT0 = 3'd1;

  // parse phase held by the front
  typedef enum logic [1:0] {
    PH_NAME,
    PH_VSTART,
    PH_VALUE,
    PH_DONE
  } nvcp_phase_e;

  // operation the back carries out for one byte
  typedef enum logic [2:0] {
    OP_NOP,
    OP_NAME_CHAR,
    OP_NEG,
    OP_DOT,
    OP_DIGIT
  } nvcp_op_e;

  // one classified byte
  typedef struct packed {
    nvcp_op_e          op;
    logic [BYTE_W-1:0] data;
    logic              last;
  } nvcp_item_t;

endpackage

// ===== rtl/nvcp_if.sv =====
// nvcp channel interfaces: byte input, result output and register write
// depends on nvcp_pkg for field widths
interface nvcp_in_if import nvcp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink   (input valid, rx_byte, frame_end, output ready);
endinterface

interface nvcp_out_if import nvcp_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [IDX_W-1:0]           name_index;
  logic signed [MANT_W-1:0]   mantissa;
  logic [PLACES_W-1:0]        decimal_places;
  logic                       saturated;

  modport source (output valid, matched, name_index, mantissa, decimal_places, saturated,
                  input ready);
  modport sink   (input valid, matched, name_index, mantissa, decimal_places, saturated,
                  output ready);
endinterface

interface nvcp_cfg_if import nvcp_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [REG_W-1:0]  index;
  logic [SLOT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/nvcp_front.sv =====
// nvcp_front: tracks the parse phase and classifies each received byte
// depends on nvcp_pkg and nvcp_in_if
module nvcp_front import nvcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  nvcp_in_if.sink     in_i,
  output nvcp_item_t  item_o,
  output logic        item_valid_o,
  input  logic        item_ready_i
);

  nvcp_phase_e phase_q, phase_d;
  nvcp_op_e    op;
  logic        accept;

  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;
  assign accept       = in_i.valid && item_ready_i;

  // classify byte by phase
  always_comb begin
    phase_d = phase_q;
    op      = OP_NOP;
    case (phase_q)
      PH_NAME: begin
        if (in_i.rx_byte == CHAR_EQ || in_i.rx_byte == CHAR_NUL) begin
          phase_d = PH_VSTART;
        end else begin
          op = OP_NAME_CHAR;
        end
      end
      PH_VSTART, PH_VALUE: begin
        phase_d = PH_VALUE;
        if (phase_q == PH_VSTART && in_i.rx_byte == CHAR_MINUS) begin
          op = OP_NEG;
        end else if (in_i.rx_byte == CHAR_HASH || in_i.rx_byte == CHAR_NUL) begin
          phase_d = PH_DONE;
        end else if (in_i.rx_byte == CHAR_DOT) begin
          op = OP_DOT;
        end else begin
          op = OP_DIGIT;
        end
      end
      default: ;
    endcase
    if (in_i.frame_end) begin
      phase_d = PH_NAME;
    end
  end

  assign item_o.op   = op;
  assign item_o.data = in_i.rx_byte;
  assign item_o.last = in_i.frame_end;

  // phase register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NAME;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== rtl/nvcp_queue.sv =====
// nvcp_queue: short register queue of classified bytes between front and back
// depends on nvcp_pkg for the item type and depth
module nvcp_queue import nvcp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  nvcp_item_t push_item_i,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  output nvcp_item_t pop_item_o,
  output logic       pop_valid_o,
  input  logic       pop_ready_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  nvcp_item_t         entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entries_q[rptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_item_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/nvcp_back.sv =====
// nvcp_back: gathers name and value, then matches the name and forms the result
// depends on nvcp_pkg and nvcp_out_if
module nvcp_back import nvcp_pkg::*; #(
  parameter int unsigned NAME_CHARS = 8,
  parameter int unsigned NAME_SLOTS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nvcp_item_t        item_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  logic [CNT_W-1:0]  name_count_i,
  input  logic [SLOT_W-1:0] slots_i [NAME_SLOTS],
  nvcp_out_if.source        out_o
);

  localparam int unsigned NAME_W = NAME_CHARS * BYTE_W;
  localparam int unsigned LEN_W  = $clog2(NAME_CHARS + 1);
  localparam int unsigned ACC_W  = MANT_W + 5;
  localparam int unsigned NEG_W  = MANT_W + 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(MANT_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(MANT_MIN);

  // slot name up to its first zero byte
  function automatic logic [NAME_W-1:0] slot_name(input logic [SLOT_W-1:0] s);
    logic [NAME_W-1:0] r;
    logic              stop;
    r    = '0;
    stop = 1'b0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (s[k*BYTE_W +: BYTE_W] == CHAR_NUL) begin
        stop = 1'b1;
      end
      if (!stop) begin
        r[k*BYTE_W +: BYTE_W] = s[k*BYTE_W +: BYTE_W];
      end
    end
    return r;
  endfunction

  // frame state
  logic [NAME_W-1:0]         name_q, name_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic                      long_q, long_d;
  logic                      neg_q, neg_d;
  logic signed [MANT_W-1:0]  sum_q, sum_d;
  logic                      dot_q, dot_d;
  logic [PLACES_W-1:0]       places_q, places_d;
  logic                      ovf_q, ovf_d;

  // finished frame stage
  logic                      fin_valid_q;
  logic [NAME_W-1:0]         fin_name_q;
  logic                      fin_long_q;
  logic                      fin_neg_q;
  logic signed [MANT_W-1:0]  fin_sum_q;
  logic [PLACES_W-1:0]       fin_places_q;
  logic                      fin_ovf_q;

  // result register
  logic                      out_valid_q;
  logic                      res_matched_q;
  logic [IDX_W-1:0]          res_index_q;
  logic signed [MANT_W-1:0]  res_mant_q;
  logic [PLACES_W-1:0]       res_places_q;
  logic                      res_sat_q;

  logic                      out_load, fin_free, pop;
  logic signed [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]          slot_lim;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;
  logic signed [NEG_W-1:0]   signed_val;
  logic signed [MANT_W-1:0]  res_mant;
  logic                      res_sat;

  // handshake between stages
  assign out_load     = !out_valid_q || out_o.ready;
  assign fin_free     = !fin_valid_q || out_load;
  assign item_ready_o = !item_i.last || fin_free;
  assign pop          = item_valid_i && item_ready_o;

  // multiply-by-ten accumulate of one value byte
  assign acc = ACC_W'(sum_q) * ACC_W'(10)
             + ACC_W'($signed({1'b0, item_i.data})) - ACC_W'(CHAR_ZERO);

  // next frame state for one item
  always_comb begin
    name_d   = name_q;
    len_d    = len_q;
    long_d   = long_q;
    neg_d    = neg_q;
    sum_d    = sum_q;
    dot_d    = dot_q;
    places_d = places_q;
    ovf_d    = ovf_q;
    case (item_i.op)
      OP_NAME_CHAR: begin
        if (len_q < LEN_W'(NAME_CHARS)) begin
          for (int k = 0; k < NAME_CHARS; k++) begin
            if (len_q == LEN_W'(k)) begin
              name_d[k*BYTE_W +: BYTE_W] = item_i.data;
            end
          end
          len_d = len_q + 1'b1;
        end else begin
          long_d = 1'b1;
        end
      end
      OP_NEG: neg_d = 1'b1;
      OP_DOT: begin
        dot_d    = 1'b1;
        places_d = '0;
      end
      OP_DIGIT: begin
        if (acc > ACC_MAX) begin
          sum_d = MANT_MAX;
          ovf_d = 1'b1;
        end else if (acc < ACC_MIN) begin
          sum_d = MANT_MIN;
          ovf_d = 1'b1;
        end else begin
          sum_d = MANT_W'(acc);
        end
        if (dot_q && places_q != PLACES_MAX) begin
          places_d = places_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // frame state registers, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q   <= '0;
      len_q    <= '0;
      long_q   <= 1'b0;
      neg_q    <= 1'b0;
      sum_q    <= '0;
      dot_q    <= 1'b0;
      places_q <= '0;
      ovf_q    <= 1'b0;
    end else if (pop) begin
      if (item_i.last) begin
        name_q   <= '0;
        len_q    <= '0;
        long_q   <= 1'b0;
        neg_q    <= 1'b0;
        sum_q    <= '0;
        dot_q    <= 1'b0;
        places_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        name_q   <= name_d;
        len_q    <= len_d;
        long_q   <= long_d;
        neg_q    <= neg_d;
        sum_q    <= sum_d;
        dot_q    <= dot_d;
        places_q <= places_d;
        ovf_q    <= ovf_d;
      end
    end
  end

  // finished frame stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (pop && item_i.last) begin
      fin_valid_q <= 1'b1;
    end else if (out_load) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.last) begin
      fin_name_q   <= name_d;
      fin_long_q   <= long_d;
      fin_neg_q    <= neg_d;
      fin_sum_q    <= sum_d;
      fin_places_q <= places_d;
      fin_ovf_q    <= ovf_d;
    end
  end

  // name match, first slot wins
  assign slot_lim = (name_count_i > CNT_W'(NAME_SLOTS)) ? CNT_W'(NAME_SLOTS) : name_count_i;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NAME_SLOTS - 1; i >= 0; i--) begin
      if (!fin_long_q && CNT_W'(i) < slot_lim && slot_name(slots_i[i]) == fin_name_q) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // apply sign, clamp the one case that leaves the range
  assign signed_val = fin_neg_q ? -NEG_W'(fin_sum_q) : NEG_W'(fin_sum_q);

  always_comb begin
    res_sat  = fin_ovf_q;
    res_mant = MANT_W'(signed_val);
    if (signed_val > NEG_W'(MANT_MAX)) begin
      res_mant = MANT_MAX;
      res_sat  = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && fin_valid_q) begin
      res_matched_q <= hit;
      res_index_q   <= hit ? hit_idx : '0;
      res_mant_q    <= hit ? res_mant : '0;
      res_places_q  <= hit ? fin_places_q : '0;
      res_sat_q     <= hit && res_sat;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.matched        = res_matched_q;
  assign out_o.name_index     = res_index_q;
  assign out_o.mantissa       = res_mant_q;
  assign out_o.decimal_places = res_places_q;
  assign out_o.saturated      = res_sat_q;

endmodule

// ===== rtl/name_value_command_parser.sv =====
// Name=value command parser, top level.
// Channels: in_i carries one frame byte per transfer (rx_byte, frame_end marks the
// last byte); out_o carries one result per frame; cfg_i writes name_count (index 0)
// and name slots 0..5 (indexes 1..6). Writes must go only while the parser is idle;
// the block does not enforce it. Bytes are classified by the front, held in a
// two-entry queue and carried out by the back, which gathers the name, accumulates
// the value and matches the name against the configured slots in a stage of its own.
// Throughput: one byte per cycle while the queue and the back do not stall; the
// multiply-by-ten accumulate in the back is combinational. The result passes from
// the queue through the finished frame stage into the result register.
// When the receiver stalls, the result register holds and the back keeps
// taking bytes until a frame's last byte meets a second finished frame that
// waits; then the queue fills and in_i.ready drops.
// Reset clears the parse state, the queue, the pending results and all
// configuration registers (name_count 0, slots zero).
// depends on nvcp_pkg, nvcp_if, nvcp_front, nvcp_queue, nvcp_back
module name_value_command_parser import nvcp_pkg::*; #(
  parameter int unsigned NAME_CHARS = 8,
  parameter int unsigned NAME_SLOTS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nvcp_in_if.sink     in_i,
  nvcp_out_if.source  out_o,
  nvcp_cfg_if.sink    cfg_i
);

  logic [CNT_W-1:0]  name_count_q;
  logic [SLOT_W-1:0] slots_q [NAME_SLOTS];
  logic              cfg_write;

  nvcp_item_t front_item, back_item;
  logic       front_valid, front_ready, back_valid, back_ready;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_count_q <= '0;
      for (int i = 0; i < NAME_SLOTS; i++) begin
        slots_q[i] <= '0;
      end
    end else if (cfg_write) begin
      if (cfg_i.index == REG_NAME_COUNT) begin
        name_count_q <= cfg_i.data[CNT_W-1:0];
      end
      for (int i = 0; i < NAME_SLOTS; i++) begin
        if (cfg_i.index == REG_NAME_SLOT0 + REG_W'(i)) begin
          slots_q[i] <= cfg_i.data;
        end
      end
    end
  end

  // byte classification
  nvcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  // decoupling queue
  nvcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (back_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  // accumulate and match
  nvcp_back #(
    .NAME_CHARS (NAME_CHARS),
    .NAME_SLOTS (NAME_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .name_count_i (name_count_q),
    .slots_i      (slots_q),
    .out_o        (out_o)
  );

`ifndef ASSERT_OFF
  // unmatched results carry zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.matched) |->
      (out_o.name_index == '0 && out_o.mantissa == '0 &&
       out_o.decimal_places == '0 && !out_o.saturated))
    else $error("unmatched result with nonzero payload");

  // a saturated mantissa sits at one end of the range or at the negated maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.saturated) |->
      (out_o.mantissa == MANT_MAX || out_o.mantissa == MANT_MIN ||
       out_o.mantissa == -MANT_MAX))
    else $error("saturated mantissa not at a limit");

  // matched index lies within the slot table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.matched) |-> (out_o.name_index < IDX_W'(NAME_SLOTS)))
    else $error("matched index out of range");
`endif

endmodule

// ===== sim/cmd_result_checker.sv =====
`timescale 1ns / 100ps
// cmd_result_checker: watches the byte, result and register channels of the parser,
// predicts each frame's result and compares it field by field
// depends on nvcp_pkg and the nvcp channel interfaces
module cmd_result_checker import nvcp_pkg::*; #(
  parameter int unsigned NAME_CHARS = 8,
  parameter int unsigned NAME_SLOTS = 6
) (
  input  logic clk_i,
  input  logic rst_ni,
  nvcp_in_if   byte_i,
  nvcp_out_if  result_i,
  nvcp_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic                     matched;
    logic [IDX_W-1:0]         name_index;
    logic signed [MANT_W-1:0] mantissa;
    logic [PLACES_W-1:0]      decimal_places;
    logic                     saturated;
  } cmd_result_t;

  // results predicted but not yet seen on the output
  cmd_result_t pending_results[$];
  cmd_result_t want;
  int          errors;

  // shadow of the name table
  logic [CNT_W-1:0]  count_reg;
  logic [SLOT_W-1:0] slot_reg [NAME_SLOTS];

  // shadow of the parse state
  nvcp_phase_e parse_phase;
  logic [63:0] name_buf;
  int unsigned name_len;
  bit          name_long;
  bit          minus_seen;
  longint      digit_acc;
  bit          dot_seen;
  int unsigned places;
  bit          over_range;

  task automatic restart_parse();
    parse_phase = PH_NAME;
    name_buf    = '0;
    name_len    = 0;
    name_long   = 0;
    minus_seen  = 0;
    digit_acc   = 0;
    dot_seen    = 0;
    places      = 0;
    over_range  = 0;
  endtask

  function automatic longint clamp_mantissa(input longint v);
    if (v > longint'(MANT_MAX)) return longint'(MANT_MAX);
    if (v < longint'(MANT_MIN)) return longint'(MANT_MIN);
    return v;
  endfunction

  // slot name as compared: low name bytes up to the first zero byte
  function automatic logic [63:0] slot_key(input logic [SLOT_W-1:0] raw);
    logic [63:0] key;
    bit          stop;
    key  = '0;
    stop = 0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      if (raw[8*k +: 8] == CHAR_NUL) stop = 1;
      if (!stop) key[8*k +: 8] = raw[8*k +: 8];
    end
    return key;
  endfunction

  // one byte of the value field
  task automatic absorb_value_byte(input logic [BYTE_W-1:0] b);
    longint raw;
    if (b == CHAR_HASH || b == CHAR_NUL) begin
      parse_phase = PH_DONE;
    end else if (b == CHAR_DOT) begin
      dot_seen = 1;
      places   = 0;
    end else begin
      raw       = digit_acc * 10 + (longint'(b) - longint'(CHAR_ZERO));
      digit_acc = clamp_mantissa(raw);
      if (digit_acc != raw) over_range = 1;
      if (dot_seen && places < PLACES_MAX) places++;
    end
  endtask

  // advance the parse by one byte; on the frame end queue the result
  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
    cmd_result_t res;
    int unsigned n;
    bit          hit;
    longint      signed_val;
    longint      clamped;
    res = '0;
    hit = 0;
    case (parse_phase)
      PH_NAME: begin
        if (b == CHAR_EQ || b == CHAR_NUL) begin
          parse_phase = PH_VSTART;
        end else if (name_len < NAME_CHARS) begin
          name_buf[8*name_len +: 8] = b;
          name_len++;
        end else begin
          name_long = 1;
        end
      end
      PH_VSTART: begin
        parse_phase = PH_VALUE;
        if (b == CHAR_MINUS) minus_seen = 1;
        else absorb_value_byte(b);
      end
      PH_VALUE: begin
        absorb_value_byte(b);
      end
      default: ;
    endcase
    if (!last) return;

    // first matching slot among the valid ones
    n = (count_reg > NAME_SLOTS) ? NAME_SLOTS : count_reg;
    if (!name_long) begin
      for (int i = 0; i < n; i++) begin
        if (!hit && slot_key(slot_reg[i]) == name_buf) begin
          hit            = 1;
          res.name_index = IDX_W'(i);
        end
      end
    end
    if (hit) begin
      signed_val         = minus_seen ? -digit_acc : digit_acc;
      clamped            = clamp_mantissa(signed_val);
      res.matched        = 1;
      res.mantissa       = clamped[MANT_W-1:0];
      res.decimal_places = PLACES_W'(places);
      res.saturated      = over_range || (clamped != signed_val);
    end
    pending_results.push_back(res);
    restart_parse();
  endtask

  task automatic check_field(input string field, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_reg = '0;
      foreach (slot_reg[i]) slot_reg[i] = '0;
      restart_parse();
      pending_results.delete();
      errors       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // register transfer
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_NAME_COUNT) begin
          count_reg = cfg_i.data[CNT_W-1:0];
        end else if (cfg_i.index >= REG_NAME_SLOT0 &&
                     cfg_i.index < REG_NAME_SLOT0 + NAME_SLOTS) begin
          slot_reg[cfg_i.index - REG_NAME_SLOT0] = cfg_i.data;
        end
      end
      // result transfer
      if (result_i.valid && result_i.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual matched=%0d index=%0d",
                   $time, result_i.matched, result_i.name_index);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("matched", want.matched, result_i.matched);
          check_field("name_index", want.name_index, result_i.name_index);
          check_field("mantissa", longint'(want.mantissa), longint'(result_i.mantissa));
          check_field("decimal_places", want.decimal_places, result_i.decimal_places);
          check_field("saturated", want.saturated, result_i.saturated);
        end
      end
      // byte transfer
      if (byte_i.valid && byte_i.ready) predict_byte(byte_i.rx_byte, byte_i.frame_end);
      fail_count_o <= errors;
      pending_o    <= pending_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives command frames and name table writes into the parser and gives
// the verdict; prediction and comparison live in cmd_result_checker
// depends on nvcp_pkg, nvcp_if, name_value_command_parser and cmd_result_checker
module testbench import nvcp_pkg::*; ;

  localparam int unsigned NAME_CHARS   = 8;
  localparam int unsigned NAME_SLOTS   = 6;
  localparam int          LATENCY_PAD  = 8;
  localparam int          HOLD_CYCLES  = 200;

  typedef logic [BYTE_W-1:0] frame_t[$];

  logic clk;
  logic rst_n;
  int   fails;
  int   pending;

  // name table as programmed
  logic [CNT_W-1:0]  count_val;
  logic [SLOT_W-1:0] slot_val [NAME_SLOTS];

  int bytes_sent;
  bit send_gaps_on;
  bit recv_gaps_on;
  bit hold_req;

  nvcp_in_if  in_if ();
  nvcp_out_if out_if ();
  nvcp_cfg_if cfg_if ();

  name_value_command_parser #(
    .NAME_CHARS (NAME_CHARS),
    .NAME_SLOTS (NAME_SLOTS)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cmd_result_checker #(
    .NAME_CHARS (NAME_CHARS),
    .NAME_SLOTS (NAME_SLOTS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_i       (in_if),
    .result_i     (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // printable name character other than the name terminator
  function automatic logic [BYTE_W-1:0] name_char();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom_range(33, 126));
    if (c == CHAR_EQ) c = "_";
    return c;
  endfunction

  // value character: mostly decimal digits, sometimes any byte
  function automatic logic [BYTE_W-1:0] value_char();
    if ($urandom_range(0, 9) == 0) return BYTE_W'($urandom_range(0, 255));
    return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [SLOT_W-1:0] random_name(input int len);
    logic [SLOT_W-1:0] v;
    v = '0;
    for (int k = 0; k < len; k++) v[8*k +: 8] = name_char();
    return v;
  endfunction

  // trash bytes behind the terminating zero of a short name
  function automatic logic [SLOT_W-1:0] with_trash(input logic [SLOT_W-1:0] v, input int len);
    logic [SLOT_W-1:0] r;
    r = v;
    for (int k = len + 1; k < 8; k++) r[8*k +: 8] = BYTE_W'($urandom_range(0, 255));
    return r;
  endfunction

  // one byte transfer on the input channel
  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.rx_byte   <= b;
    in_if.frame_end <= last;
    do @(posedge clk); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_t f);
    foreach (f[k]) put_byte(f[k], k == f.size() - 1);
  endtask

  // write the count and all six slots, one transfer each
  task automatic program_table();
    for (int k = 0; k <= NAME_SLOTS; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= (k == 0) ? REG_NAME_COUNT : REG_NAME_SLOT0 + REG_W'(k - 1);
      cfg_if.data  <= (k == 0) ? SLOT_W'(count_val) : slot_val[k - 1];
      do @(posedge clk); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // stop offering and wait for every predicted result plus some margin
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // random frame: mostly well formed with random content, some broken, some noise
  task automatic build_frame(output frame_t f);
    int kind, n, len, dot_at, r;
    logic [BYTE_W-1:0] c;
    f    = {};
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 16);
      repeat (n) f.push_back(BYTE_W'($urandom_range(0, 255)));
      return;
    end
    // name: a configured one, an overlong one or a random one
    n = (count_val > NAME_SLOTS) ? NAME_SLOTS : count_val;
    if (kind < 75 && n > 0) begin
      r = $urandom_range(0, n - 1);
      for (int k = 0; k < NAME_CHARS; k++) begin
        c = slot_val[r][8*k +: 8];
        if (c == CHAR_NUL) break;
        f.push_back(c);
      end
    end else begin
      len = (kind < 85) ? $urandom_range(NAME_CHARS + 1, NAME_CHARS + 4)
                        : $urandom_range(0, NAME_CHARS);
      repeat (len) f.push_back(name_char());
    end
    // frame may end inside the name
    r = $urandom_range(0, 19);
    if (r == 0) begin
      if (f.size() == 0) f.push_back(name_char());
      return;
    end
    f.push_back((r < 3) ? CHAR_NUL : CHAR_EQ);
    if ($urandom_range(0, 2) == 0) f.push_back(CHAR_MINUS);
    // digits, long runs push the mantissa out of range
    n      = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6) : $urandom_range(9, 14);
    dot_at = ($urandom_range(0, 9) < 4) ? $urandom_range(0, n) : -1;
    for (int k = 0; k <= n; k++) begin
      if (k == dot_at) f.push_back(CHAR_DOT);
      if (k < n) f.push_back(value_char());
    end
    r = $urandom_range(0, 19);
    if (r < 15) f.push_back(CHAR_HASH);
    else if (r < 17) f.push_back(CHAR_NUL);
    // trailing bytes, ignored after a terminator, part of the value without one
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) f.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random(input int count);
    frame_t f;
    int     stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      build_frame(f);
      send_frame(f);
    end
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req     = 0;
        stall_left   = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (recv_gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left   = pick_gap();
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    frame_t f;
    in_if.valid     = 1'b0;
    in_if.rx_byte   = '0;
    in_if.frame_end = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    send_gaps_on    = 0;
    recv_gaps_on    = 0;
    hold_req        = 0;
    bytes_sent      = 0;
    rst_n           = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: count above the slot limit, empty name with trash behind its zero
    count_val   = 3'd7;
    slot_val[0] = 64'h78;
    slot_val[1] = 64'hFF00;
    for (int k = 2; k < NAME_SLOTS; k++) slot_val[k] = '0;
    program_table();
    send_frame('{"x", CHAR_EQ, CHAR_MINUS, "1", CHAR_DOT, "5", CHAR_HASH});
    send_frame('{CHAR_EQ, "7"});
    send_frame('{"x", CHAR_NUL, 8'hFF});
    send_frame('{"x"});
    send_frame('{"x", CHAR_EQ, "9", "9", "9", "9", "9", "9", "9", "9", "9", "9"});
    drain();

    // six clean names, one frame with enough decimals to hit the places limit
    count_val   = 3'd6;
    slot_val[0] = 64'h647073;
    for (int k = 1; k < NAME_SLOTS; k++) slot_val[k] = random_name(k + 3);
    send_gaps_on = 1;
    recv_gaps_on = 1;
    program_table();
    f = '{"s", "p", "d", CHAR_EQ, "3", CHAR_DOT};
    repeat (260) f.push_back(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
    f.push_back(CHAR_HASH);
    send_frame(f);
    send_random(500);
    drain();

    // trash behind names, duplicate name, no idling, long receiver hold
    count_val   = 3'd3;
    slot_val[0] = random_name(2);
    slot_val[2] = with_trash(slot_val[0], 2);
    slot_val[0] = with_trash(slot_val[0], 2);
    slot_val[1] = with_trash(random_name(5), 5);
    for (int k = 3; k < NAME_SLOTS; k++) slot_val[k] = {$urandom, $urandom};
    send_gaps_on = 0;
    recv_gaps_on = 0;
    program_table();
    hold_req = 1;
    send_random(500);
    drain();

    // empty table: nothing matches
    count_val    = 3'd0;
    send_gaps_on = 1;
    recv_gaps_on = 1;
    program_table();
    send_random(250);
    drain();

    // raw random slot contents, random count
    count_val   = CNT_W'($urandom_range(4, 7));
    slot_val[0] = random_name($urandom_range(1, NAME_CHARS));
    slot_val[1] = random_name(NAME_CHARS);
    for (int k = 2; k < NAME_SLOTS; k++) slot_val[k] = {$urandom, $urandom};
    send_gaps_on = 0;
    recv_gaps_on = 1;
    program_table();
    send_random(300);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("name_value_command_parser regression: pass");
    end else begin
      $display("name_value_command_parser regression: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("name_value_command_parser regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nvcp_pkg.sv
rtl/nvcp_if.sv
rtl/nvcp_front.sv
rtl/nvcp_queue.sv
rtl/nvcp_back.sv
rtl/name_value_command_parser.sv
sim/cmd_result_checker.sv
sim/testbench.sv
